FILE: sv/pmq_pkg.sv
// Package for the probability mass quantizer: widths, defaults and sequencer states.
// No dependencies.
package pmq_pkg;
  localparam int unsigned MaxSymbolsDef = 64;
  localparam int unsigned FracBitsDef   = 16;
  localparam int unsigned MassW         = 25;
  localparam int unsigned ScoreW        = 32;
  localparam int unsigned SymW          = 6;
  localparam logic [MassW-1:0] MassReset = 25'd65536;

  typedef enum logic [3:0] {
    StLoad,
    StSortRd,
    StSortCur,
    StSortCmp,
    StSortPut,
    StRangeHi,
    StRangeLo,
    StNormRd,
    StNormStart,
    StNormWait,
    StMassRd,
    StMassStart,
    StMassWait,
    StMassTop,
    StEmitRd,
    StEmit
  } state_e;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage

FILE: sv/pmq_ram.sv
// Generic single-port write, single-port registered read RAM.
// No dependencies.
module pmq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: sv/pmq_div.sv
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on pmq_pkg.
module pmq_div
  import pmq_pkg::*;
#(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output div_ctl_t     ctl_o,
  output logic [W-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(W + 1);
  logic [W-1:0]    rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [W:0]      trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quo_q[W-1]} - {1'b0, den_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
      cnt_d  = CntW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign ctl_o.start = start_i;
  assign ctl_o.busy  = busy_q;
  assign quot_o      = quo_q;
endmodule

FILE: sv/probability_mass_quantizer.sv
// Top level of the probability mass quantizer: sequencer, stores and shared divider.
// Depends on pmq_pkg, pmq_ram and pmq_div.
//
//  channel | dir | fields
//  s_axis  | in  | tdata = score[31:0], tlast = last
//  m_axis  | out | tdata = {mass[30:6], symbol[5:0]}, tuser = {final_res, error}
//  cfg     | in  | mass budget, written whenever cfg_we_i is high
//
// Loading takes one word per cycle. After the last word the insertion sort places each
// symbol, one shift per lower score passed (at most n*(n-1)/2 shifts), the range is
// read from the top and bottom ranks, and every normalization (unless all scores are
// equal) and every mass but the top one take a pass through the shared divider. The
// input is not ready until the last result word is taken. A stalled result word is
// held. Reset clears the sequencer and counters and sets the mass budget to its
// default; the stores are not cleared, only current entries are read.
module probability_mass_quantizer
  import pmq_pkg::*;
#(
  parameter int unsigned MaxSymbols = MaxSymbolsDef,
  parameter int unsigned FracBits   = FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [24:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // score[31:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // symbol[5:0], mass[30:6], zero[31]
  output logic [1:0]  m_axis_tuser    // error[0], final_res[1]
);
  localparam int unsigned AW = $clog2(MaxSymbols);
  localparam int unsigned CW = $clog2(MaxSymbols + 1);
  localparam int unsigned DW = ScoreW + FracBits;
  localparam int unsigned NW = FracBits + AW + 2;
  localparam int unsigned SW = MassW + AW + 1;
  localparam int unsigned PW = FracBits + MassW + 1;

  state_e st_q, st_d;
  logic [MassW-1:0]  total_q;
  logic [CW-1:0]     cnt_q, cnt_d, i_q, i_d, j_q, j_d;
  logic [AW-1:0]     cur_q, cur_d;
  logic signed [ScoreW-1:0] cur_s_q, cur_s_d, min_q, min_d, max_q, max_d;
  logic [NW-1:0]     sum_q, sum_d;
  logic [SW-1:0]     spent_q, spent_d;
  logic              err_q, err_d;

  logic              sc_we, ord_we, mr_we;
  logic [AW-1:0]     sc_wa, sc_ra, ord_wa, ord_ra, mr_wa, mr_ra;
  logic [ScoreW-1:0] sc_wd, sc_rd;
  logic [ScoreW+AW-1:0] ord_wd, ord_rd;
  logic [MassW-1:0]  mr_wd, mr_rd;
  logic              dstart;
  logic [DW-1:0]     dnum, dden, dquo;
  div_ctl_t          dctl;
  logic              norm_adv;

  // Sorted store entries hold {score, symbol}; the mass store first holds the
  // normalized value of each rank and later its mass.
  pmq_ram #(.Width(ScoreW), .Depth(MaxSymbols)) u_score (
    .clk_i, .we_i(sc_we), .waddr_i(sc_wa), .wdata_i(sc_wd),
    .raddr_i(sc_ra), .rdata_o(sc_rd));
  pmq_ram #(.Width(ScoreW + AW), .Depth(MaxSymbols)) u_order (
    .clk_i, .we_i(ord_we), .waddr_i(ord_wa), .wdata_i(ord_wd),
    .raddr_i(ord_ra), .rdata_o(ord_rd));
  pmq_ram #(.Width(MassW), .Depth(MaxSymbols)) u_mass (
    .clk_i, .we_i(mr_we), .waddr_i(mr_wa), .wdata_i(mr_wd),
    .raddr_i(mr_ra), .rdata_o(mr_rd));
  pmq_div #(.W(DW)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(dden),
    .ctl_o(dctl), .quot_o(dquo));

  logic signed [ScoreW-1:0] rd_score;
  logic [ScoreW:0]   span, off;
  logic [CW-1:0]     i_p1, cnt_m1, j_m1, j_m2;
  logic [PW-1:0]     prod;
  logic [MassW-1:0]  mass_val, top_mass;
  logic [SymW-1:0]   sym_out;

  assign rd_score = ord_rd[AW +: ScoreW];
  assign span     = {max_q[ScoreW-1], max_q} - {min_q[ScoreW-1], min_q};
  assign off      = {rd_score[ScoreW-1], rd_score} - {min_q[ScoreW-1], min_q};
  assign i_p1     = i_q + CW'(1);
  assign cnt_m1   = cnt_q - CW'(1);
  assign j_m1     = j_q - CW'(1);
  assign j_m2     = j_q - CW'(2);
  assign prod     = mr_rd[FracBits:0] * total_q;
  // A mass that rounds down to zero is raised to one.
  assign mass_val = (dquo == '0) ? MassW'(1) : dquo[MassW-1:0];
  assign top_mass = total_q - spent_q[MassW-1:0];
  assign sym_out  = SymW'(ord_rd[AW-1:0]);

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q; cur_d = cur_q;
    cur_s_d = cur_s_q; min_d = min_q; max_d = max_q; sum_d = sum_q;
    spent_d = spent_q; err_d = err_q;
    sc_we = 1'b0; sc_wa = cnt_q[AW-1:0]; sc_wd = s_axis_tdata; sc_ra = '0;
    ord_we = 1'b0; ord_wa = '0; ord_wd = '0; ord_ra = '0;
    mr_we = 1'b0; mr_wa = '0; mr_wd = '0; mr_ra = '0;
    dstart = 1'b0; dnum = '0; dden = '0; norm_adv = 1'b0;
    s_axis_tready = 1'b0; m_axis_tvalid = 1'b0;
    case (st_q)
      // Scores beyond the store depth are dropped, but their last flag still counts.
      StLoad: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (cnt_q < CW'(MaxSymbols)) begin
            sc_we = 1'b1;
            cnt_d = cnt_q + CW'(1);
          end
          if (s_axis_tlast) begin
            i_d = '0; st_d = StSortRd;
          end
        end
      end
      // Insertion sort into the sorted store; only strictly lower scores move down,
      // so equal scores keep the lower symbol first.
      StSortRd: begin
        if (i_q == cnt_q) begin
          ord_ra = '0; st_d = StRangeHi;
        end else begin
          sc_ra = i_q[AW-1:0]; j_d = i_q; st_d = StSortCur;
        end
      end
      StSortCur: begin
        cur_s_d = sc_rd; cur_d = i_q[AW-1:0];
        if (j_q == '0) begin
          ord_we = 1'b1; ord_wa = '0; ord_wd = {sc_rd, i_q[AW-1:0]};
          i_d = i_p1; st_d = StSortRd;
        end else begin
          ord_ra = j_m1[AW-1:0]; st_d = StSortCmp;
        end
      end
      StSortCmp: begin
        if (rd_score < cur_s_q) begin
          ord_we = 1'b1; ord_wa = j_q[AW-1:0]; ord_wd = ord_rd;
          j_d = j_m1;
          if (j_q == CW'(1)) begin
            st_d = StSortPut;
          end else begin
            ord_ra = j_m2[AW-1:0];
          end
        end else begin
          ord_we = 1'b1; ord_wa = j_q[AW-1:0]; ord_wd = {cur_s_q, cur_q};
          i_d = i_p1; st_d = StSortRd;
        end
      end
      StSortPut: begin
        ord_we = 1'b1; ord_wa = '0; ord_wd = {cur_s_q, cur_q};
        i_d = i_p1; st_d = StSortRd;
      end
      // The top rank holds the maximum and the bottom rank the minimum.
      StRangeHi: begin
        max_d = rd_score; ord_ra = cnt_m1[AW-1:0]; st_d = StRangeLo;
      end
      StRangeLo: begin
        min_d = rd_score; sum_d = NW'(1) << FracBits; i_d = '0; st_d = StNormRd;
      end
      StNormRd: begin
        ord_ra = i_q[AW-1:0]; st_d = StNormStart;
      end
      StNormStart: begin
        if (span == '0) begin
          // All scores equal: every normalized value is zero.
          mr_we = 1'b1; mr_wa = i_q[AW-1:0]; mr_wd = '0;
          norm_adv = 1'b1;
        end else begin
          dstart = 1'b1; dnum = DW'(off) << FracBits; dden = DW'(span);
          st_d = StNormWait;
        end
      end
      StNormWait: begin
        if (!dctl.busy && !dctl.start) begin
          mr_we = 1'b1; mr_wa = i_q[AW-1:0]; mr_wd = MassW'(dquo);
          sum_d = sum_q + NW'(dquo);
          norm_adv = 1'b1;
        end
      end
      // Masses from the lowest rank up to the second one.
      StMassRd: begin
        mr_ra = i_q[AW-1:0]; st_d = StMassStart;
      end
      StMassStart: begin
        dstart = 1'b1; dnum = DW'(prod); dden = DW'(sum_q);
        st_d = StMassWait;
      end
      StMassWait: begin
        if (!dctl.busy && !dctl.start) begin
          mr_we = 1'b1; mr_wa = i_q[AW-1:0]; mr_wd = mass_val;
          spent_d = spent_q + SW'(mass_val);
          if (i_q == CW'(1)) begin
            st_d = StMassTop;
          end else begin
            i_d = i_q - CW'(1); st_d = StMassRd;
          end
        end
      end
      // The top rank takes what is left; none left flags the whole run.
      StMassTop: begin
        err_d = spent_q >= SW'(total_q);
        mr_we = 1'b1; mr_wa = '0;
        mr_wd = (spent_q >= SW'(total_q)) ? '0 : top_mass;
        i_d = '0; st_d = StEmitRd;
      end
      StEmitRd: begin
        ord_ra = i_q[AW-1:0]; mr_ra = i_q[AW-1:0]; st_d = StEmit;
      end
      // The read address stays put during a stall, so the word is held.
      StEmit: begin
        m_axis_tvalid = 1'b1;
        ord_ra = i_q[AW-1:0]; mr_ra = i_q[AW-1:0];
        if (m_axis_tready) begin
          if (i_q == cnt_m1) begin
            cnt_d = '0; i_d = '0; st_d = StLoad;
          end else begin
            i_d = i_p1; ord_ra = i_p1[AW-1:0]; mr_ra = i_p1[AW-1:0];
          end
        end
      end
      default: st_d = StLoad;
    endcase
    if (norm_adv) begin
      i_d = i_p1;
      if (i_q == cnt_m1) begin
        spent_d = '0;
        if (cnt_q == CW'(1)) begin
          st_d = StMassTop;
        end else begin
          i_d = cnt_m1; st_d = StMassRd;
        end
      end else begin
        st_d = StNormRd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad; cnt_q <= '0; total_q <= MassReset;
      i_q <= '0; j_q <= '0; err_q <= 1'b0; cur_q <= '0; cur_s_q <= '0;
      min_q <= '0; max_q <= '0; sum_q <= '0; spent_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; i_q <= i_d; j_q <= j_d; err_q <= err_d;
      cur_q <= cur_d; cur_s_q <= cur_s_d; min_q <= min_d; max_q <= max_d;
      sum_q <= sum_d; spent_q <= spent_d;
      if (cfg_we_i) total_q <= cfg_wdata_i;
    end
  end

  assign m_axis_tdata = {1'b0, mr_rd, sym_out};
  assign m_axis_tuser = {(i_q == cnt_m1), err_q};

  a_ready_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> st_q == StLoad) else $error("ready outside load");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MaxSymbols)) else $error("count overflow");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser)) else $error("result word changed during stall");
endmodule
